/* src/opmac_pkg.sv */
// ----------------------------------------------------------------------------
// opmac_pkg
// Shared types and constants for the 6x8 outer-product multiply-accumulate array.
// ----------------------------------------------------------------------------
package opmac_pkg;

   localparam int TILE_ROWS = 6;
   localparam int TILE_COLS = 8;
   localparam int ELEM_W    = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = 40;
   localparam int MAX_DEPTH = 256;
   localparam int CNT_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int ROW_W     = $clog2(TILE_ROWS);

   // request beat layout: a rows 0..5 then b columns 0..7
   localparam int A_LSB     = 0;
   localparam int B_LSB     = A_LSB + TILE_ROWS * ELEM_W;
   localparam int REQ_BITS  = B_LSB + TILE_COLS * ELEM_W;
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8;

   // response beat layout: row index then eight accumulators
   localparam int RSP_BITS  = ROW_W + TILE_COLS * ACC_W;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [TILE_COLS-1:0] b_vec_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef acc_type [TILE_COLS-1:0]  acc_row_type;

   typedef struct packed {
      logic load;     // capture products of an accepted beat
      logic advance;  // fold held products into the accumulators
      logic final_k;  // advancing step closes the run
   } lane_ctl_type;

endpackage

/* src/outer_product_mac_array_6x8_core.sv */
// ----------------------------------------------------------------------------
// outer_product_mac_array_6x8_core
// Rank-1 update engine for a 6x8 tile with saturating 40-bit accumulators.
//
//   channel | dir | tdata                              | tlast
//   req_    | in  | a rows 0..5, b cols 0..7 (Q1.15)   | final k-step
//   rsp_    | out | row index, acc cols 0..7 (Q10.30)  | row 5 of the tile
//
// one request beat per cycle unless a closing step waits on the bank; products are registered, then accumulated
// a closing k-step (tlast, or the 256th of a run) snapshots all 48 sums into
// the result bank, which sends six rows, one beat each, while the next run
// accumulates; a closing step waits while the bank still holds rows
// reset clears accumulators, the run counter and the bank state at once
// ----------------------------------------------------------------------------
module outer_product_mac_array_6x8_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_rows_0_to_3[63:0], a_rows_4_5[95:64], b_cols_0_to_3[159:96],
   // b_cols_4_to_7[223:160]
   input  logic [opmac_pkg::REQ_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // row_index[2:0], acc_col0[42:3] .. acc_col7[322:283], zero pad above
   output logic [opmac_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast
);
   import opmac_pkg::*;

   logic             req_beat;
   logic             final_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             prod_valid_ff, prod_valid_in;
   logic             prod_final_ff, prod_final_in;
   logic             advance;
   logic             bank_busy;
   lane_ctl_type     lane_ctl;
   acc_row_type      lane_rows [TILE_ROWS];
   logic [ROW_W-1:0] row_index;
   acc_row_type      row_data;

   assign advance    = prod_valid_ff && (!prod_final_ff || !bank_busy);
   assign req_tready = !prod_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;
   assign final_in   = req_tlast || (count_ff == CNT_W'(MAX_DEPTH - 1));

   assign lane_ctl.load    = req_beat;
   assign lane_ctl.advance = advance;
   assign lane_ctl.final_k = prod_final_ff;

   always_comb begin
      count_in      = count_ff;
      prod_valid_in = prod_valid_ff;
      prod_final_in = prod_final_ff;
      if (req_beat) begin
         count_in      = final_in ? '0 : count_ff + CNT_W'(1);
         prod_valid_in = 1'b1;
         prod_final_in = final_in;
      end else if (advance) begin
         prod_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         prod_valid_ff <= 1'b0;
         prod_final_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         prod_valid_ff <= prod_valid_in;
         prod_final_ff <= prod_final_in;
      end
   end

   for (genvar i = 0; i < TILE_ROWS; i++) begin : g_lane
      opmac_row_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .a_elem  (elem_type'(req_tdata[A_LSB + ELEM_W*i +: ELEM_W])),
         .b_elems (b_vec_type'(req_tdata[B_LSB +: ELEM_W*TILE_COLS])),
         .sum_row (lane_rows[i])
      );
   end

   opmac_row_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .capture    (advance && prod_final_ff),
      .lane_rows  (lane_rows),
      .busy       (bank_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .row_index  (row_index),
      .row_data   (row_data),
      .last_row   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_W - RSP_BITS)'(0), row_data, row_index};

   // a snapshot never lands on a bank that still holds rows
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance && prod_final_ff |-> !bank_busy)
      else $error("result bank overwritten");

   // stalls only come from a closing step waiting on the bank
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> prod_valid_ff && prod_final_ff && bank_busy)
      else $error("unexpected request stall");

   // each tile starts with row 0
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> row_index == '0)
      else $error("tile does not start at row 0");

   // the bank empties after the last row leaves
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("bank still busy after last row");

endmodule

/* src/opmac_row_lane.sv */
// ----------------------------------------------------------------------------
// opmac_row_lane
// One tile row: eight multipliers into eight saturating 40-bit accumulators.
// ----------------------------------------------------------------------------
module opmac_row_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  opmac_pkg::lane_ctl_type ctl,
   input  opmac_pkg::elem_type   a_elem,
   input  opmac_pkg::b_vec_type  b_elems,
   output opmac_pkg::acc_row_type sum_row
);
   import opmac_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [TILE_COLS];
   logic signed [PROD_W-1:0] prod_in [TILE_COLS];
   acc_type                  acc_ff  [TILE_COLS];
   acc_type                  acc_in  [TILE_COLS];
   logic signed [ACC_W:0]    wide_sum [TILE_COLS];

   always_comb begin
      for (int j = 0; j < TILE_COLS; j++) begin
         prod_in[j]  = $signed(a_elem) * $signed(b_elems[j]);
         wide_sum[j] = (ACC_W+1)'(acc_ff[j]) + (ACC_W+1)'(prod_ff[j]);
         // clamp when the extra sign bit disagrees
         if (wide_sum[j][ACC_W] != wide_sum[j][ACC_W-1]) begin
            sum_row[j] = wide_sum[j][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            sum_row[j] = wide_sum[j][ACC_W-1:0];
         end
         acc_in[j] = ctl.final_k ? '0 : sum_row[j];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int j = 0; j < TILE_COLS; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TILE_COLS; j++) begin
            acc_ff[j] <= '0;
         end
      end else if (ctl.advance) begin
         for (int j = 0; j < TILE_COLS; j++) begin
            acc_ff[j] <= acc_in[j];
         end
      end
   end

endmodule

/* src/opmac_row_drain.sv */
// ----------------------------------------------------------------------------
// opmac_row_drain
// Result bank: takes a snapshot of all six lanes and shifts rows out in order.
// ----------------------------------------------------------------------------
module opmac_row_drain (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     capture,
   input  opmac_pkg::acc_row_type   lane_rows [opmac_pkg::TILE_ROWS],
   output logic                     busy,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [opmac_pkg::ROW_W-1:0] row_index,
   output opmac_pkg::acc_row_type   row_data,
   output logic                     last_row
);
   import opmac_pkg::*;

   acc_row_type      bank_ff [TILE_ROWS];
   acc_row_type      bank_in [TILE_ROWS];
   logic             busy_ff, busy_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             rsp_beat;

   assign rsp_beat   = busy_ff && rsp_tready;
   assign busy       = busy_ff;
   assign rsp_tvalid = busy_ff;
   assign row_index  = row_ff;
   assign row_data   = bank_ff[0];
   assign last_row   = (row_ff == ROW_W'(TILE_ROWS - 1));

   always_comb begin
      bank_in = bank_ff;
      busy_in = busy_ff;
      row_in  = row_ff;
      if (capture) begin
         bank_in = lane_rows;
         busy_in = 1'b1;
         row_in  = '0;
      end else if (rsp_beat) begin
         // the row being sent always sits at the head of the bank
         for (int r = 0; r < TILE_ROWS - 1; r++) begin
            bank_in[r] = bank_ff[r+1];
         end
         row_in = row_ff + ROW_W'(1);
         if (last_row) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
      end
   end

endmodule
